>>> design/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the config text tokenizer
// Lexer modes, result kinds, character codes and the result beat layout.
// ----------------------------------------------------------------------------
package ctt_pkg;

	// field widths
	localparam int BYTE_W       = 8;
	localparam int KIND_W       = 3;
	localparam int OUT_POS_W    = 16;
	localparam int POS_BITS_DEF = 16;

	// result queue geometry
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;

	// character codes
	localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
	localparam logic [BYTE_W-1:0] CH_DQUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE  = 8'h27;
	localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PRT_LO  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_PRT_HI  = 8'h7E;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_NAME    = 2'd1,
		MODE_COMMENT = 2'd2,
		MODE_STRING  = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NAME_CHAR   = 3'd0,
		KIND_NAME_END    = 3'd1,
		KIND_BLOCK_START = 3'd2,
		KIND_BLOCK_END   = 3'd3,
		KIND_STMT_END    = 3'd4,
		KIND_INPUT_END   = 3'd5,
		KIND_AFTER_END   = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [BYTE_W-1:0]      data;
		logic [OUT_POS_W-1:0]   row;
		logic [OUT_POS_W-1:0]   col;
		logic                   last;
	} result_t;

endpackage

>>> design/ctt_if.sv
// ----------------------------------------------------------------------------
// ctt_if: valid/ready channels of the config text tokenizer
// Input byte channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface ctt_in_if;
	logic                         valid;
	logic                         ready;
	logic [ctt_pkg::BYTE_W-1:0]   in_byte;
	logic                         in_end;

	modport source (output valid, output in_byte, output in_end, input ready);
	modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface ctt_out_if;
	logic                           valid;
	logic                           ready;
	logic [ctt_pkg::KIND_W-1:0]     kind;
	logic [ctt_pkg::BYTE_W-1:0]     out_byte;
	logic [ctt_pkg::OUT_POS_W-1:0]  row;
	logic [ctt_pkg::OUT_POS_W-1:0]  col;
	logic                           last;

	modport source (output valid, output kind, output out_byte, output row, output col,
		output last, input ready);
	modport sink   (input valid, input kind, input out_byte, input row, input col,
		input last, output ready);
endinterface

>>> design/ctt_res_fifo.sv
// ----------------------------------------------------------------------------
// ctt_res_fifo: small result queue
// Takes zero, one or two result beats per cycle and hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module ctt_res_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [1:0]                     push_n,
	input  ctt_pkg::result_t               push_a,
	input  ctt_pkg::result_t               push_b,
	input  logic                           pop,
	output logic                           head_valid,
	output ctt_pkg::result_t               head,
	output logic [ctt_pkg::RES_CNT_W-1:0]  level
);

	ctt_pkg::result_t                 entry_q [ctt_pkg::RES_DEPTH];
	logic [ctt_pkg::RES_PTR_W-1:0]    wr_ptr_q;
	logic [ctt_pkg::RES_PTR_W-1:0]    rd_ptr_q;
	logic [ctt_pkg::RES_CNT_W-1:0]    cnt_q;
	logic [ctt_pkg::RES_PTR_W-1:0]    wr_ptr_nx;
	logic                             do_pop;

	assign do_pop    = pop && (cnt_q != '0);
	assign wr_ptr_nx = wr_ptr_q + ctt_pkg::RES_PTR_W'(1);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ctt_pkg::RES_PTR_W'(push_n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ctt_pkg::RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + ctt_pkg::RES_CNT_W'(push_n) - ctt_pkg::RES_CNT_W'(do_pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			entry_q[wr_ptr_nx] <= push_b;
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign level      = cnt_q;

endmodule

>>> design/config_text_tokenizer.sv
// ----------------------------------------------------------------------------
// config_text_tokenizer: streaming lexer for configuration text
// Splits a byte stream into name characters, name ends, braces, statement
// ends, end-of-input and after-end marks, each tagged with its row and column.
// ----------------------------------------------------------------------------
// Path: a byte is registered in the input stage, then its results in the queue.
// Throughput: one byte per cycle while each byte gives at most one result and
//   the result port is not stalled; a byte with two results needs two beats
//   of the single result port, which drains the 4-entry result queue.
// Reset: arst_n clears lexer mode, quote, counters (row and col to 1), the
//   end flag, the input stage and the result queue at once.
module config_text_tokenizer #(
	parameter int POS_BITS = ctt_pkg::POS_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ctt_in_if.sink         in_ch,
	ctt_out_if.source      out_ch
);

	localparam int EXT_W = (POS_BITS > ctt_pkg::OUT_POS_W) ? POS_BITS : ctt_pkg::OUT_POS_W;

	// input stage
	logic                          valid_s1;
	logic [ctt_pkg::BYTE_W-1:0]    byte_s1;
	logic                          end_s1;

	// lexer state
	ctt_pkg::mode_t                mode_q;
	logic [ctt_pkg::BYTE_W-1:0]    quote_q;
	logic [POS_BITS-1:0]           row_q;
	logic [POS_BITS-1:0]           col_q;
	logic                          ended_q;

	ctt_pkg::mode_t                mode_nx;
	logic [ctt_pkg::BYTE_W-1:0]    quote_nx;
	logic                          ended_nx;
	logic [POS_BITS-1:0]           row_post;
	logic [POS_BITS-1:0]           col_post;
	logic                          adv;

	// slot a: position before the byte, slot b: position after it
	logic                          a_v;
	logic                          b_v;
	ctt_pkg::kind_t                b_kind;
	logic [ctt_pkg::BYTE_W-1:0]    b_data;
	ctt_pkg::result_t              res_a;
	ctt_pkg::result_t              res_b;
	ctt_pkg::result_t              push_a;
	ctt_pkg::result_t              push_b;
	logic [1:0]                    push_n;

	logic                          proc;
	logic                          in_fire;
	logic                          is_space;
	logic                          is_ident;
	logic [ctt_pkg::RES_CNT_W-1:0] level;
	logic                          head_valid;
	ctt_pkg::result_t              head;

	function automatic logic [ctt_pkg::OUT_POS_W-1:0] sat_pos(input logic [POS_BITS-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if (ext > EXT_W'({ctt_pkg::OUT_POS_W{1'b1}})) begin
			return {ctt_pkg::OUT_POS_W{1'b1}};
		end
		return ext[ctt_pkg::OUT_POS_W-1:0];
	endfunction

	// input handshake: the stage moves on when the queue has room for two beats
	assign proc        = valid_s1 && (level <= ctt_pkg::RES_CNT_W'(ctt_pkg::RES_DEPTH - 2));
	assign in_ch.ready = !valid_s1 || proc;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.in_byte;
			end_s1  <= in_ch.in_end;
		end
	end

	// byte classes
	assign is_space = (byte_s1 == ctt_pkg::CH_SPACE) ||
		(byte_s1 >= ctt_pkg::CH_TAB && byte_s1 <= ctt_pkg::CH_CR);
	assign is_ident = (byte_s1 >= ctt_pkg::CH_PRT_LO) && (byte_s1 <= ctt_pkg::CH_PRT_HI) &&
		!(byte_s1 inside {ctt_pkg::CH_SEMI, ctt_pkg::CH_LBRACE, ctt_pkg::CH_RBRACE,
			ctt_pkg::CH_SQUOTE, ctt_pkg::CH_DQUOTE, ctt_pkg::CH_HASH});

	// saturating row and column after the byte
	assign adv = !ended_q && !end_s1;
	always_comb begin
		row_post = row_q;
		col_post = col_q;
		if (adv) begin
			if (byte_s1 == ctt_pkg::CH_NL) begin
				if (row_q != '1) begin
					row_post = row_q + POS_BITS'(1);
				end
				col_post = POS_BITS'(1);
			end else if (col_q != '1) begin
				col_post = col_q + POS_BITS'(1);
			end
		end
	end

	// lexer decisions for the byte in the input stage
	always_comb begin
		mode_nx  = mode_q;
		quote_nx = quote_q;
		ended_nx = ended_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		b_kind   = ctt_pkg::KIND_NAME_CHAR;
		b_data   = '0;
		if (ended_q) begin
			b_v    = 1'b1;
			b_kind = ctt_pkg::KIND_AFTER_END;
		end else if (end_s1) begin
			a_v      = (mode_q == ctt_pkg::MODE_NAME) || (mode_q == ctt_pkg::MODE_STRING);
			b_v      = 1'b1;
			b_kind   = ctt_pkg::KIND_INPUT_END;
			mode_nx  = ctt_pkg::MODE_IDLE;
			quote_nx = '0;
			ended_nx = 1'b1;
		end else if (mode_q == ctt_pkg::MODE_COMMENT) begin
			if (byte_s1 == ctt_pkg::CH_NL) begin
				mode_nx = ctt_pkg::MODE_IDLE;
			end
		end else if (mode_q == ctt_pkg::MODE_STRING) begin
			b_v = 1'b1;
			if (byte_s1 == quote_q || byte_s1 == ctt_pkg::CH_NL) begin
				b_kind   = ctt_pkg::KIND_NAME_END;
				mode_nx  = ctt_pkg::MODE_IDLE;
				quote_nx = '0;
			end else begin
				b_data = byte_s1;
			end
		end else if (mode_q == ctt_pkg::MODE_NAME && is_ident) begin
			b_v    = 1'b1;
			b_data = byte_s1;
		end else begin
			// name ends first if one is open, then the byte is taken as in idle mode
			a_v     = (mode_q == ctt_pkg::MODE_NAME);
			mode_nx = ctt_pkg::MODE_IDLE;
			if (is_space) begin
				mode_nx = ctt_pkg::MODE_IDLE;
			end else if (byte_s1 == ctt_pkg::CH_HASH) begin
				mode_nx = ctt_pkg::MODE_COMMENT;
			end else if (is_ident) begin
				b_v     = 1'b1;
				b_data  = byte_s1;
				mode_nx = ctt_pkg::MODE_NAME;
			end else if (byte_s1 == ctt_pkg::CH_SQUOTE || byte_s1 == ctt_pkg::CH_DQUOTE) begin
				quote_nx = byte_s1;
				mode_nx  = ctt_pkg::MODE_STRING;
			end else if (byte_s1 == ctt_pkg::CH_LBRACE) begin
				b_v    = 1'b1;
				b_kind = ctt_pkg::KIND_BLOCK_START;
			end else if (byte_s1 == ctt_pkg::CH_RBRACE) begin
				b_v    = 1'b1;
				b_kind = ctt_pkg::KIND_BLOCK_END;
			end else if (byte_s1 == ctt_pkg::CH_SEMI) begin
				b_v    = 1'b1;
				b_kind = ctt_pkg::KIND_STMT_END;
			end
		end
	end

	// result beats, packed to the front of the queue
	always_comb begin
		res_a.kind = ctt_pkg::KIND_NAME_END;
		res_a.data = '0;
		res_a.row  = sat_pos(row_q);
		res_a.col  = sat_pos(col_q);
		res_a.last = !b_v;
		res_b.kind = b_kind;
		res_b.data = b_data;
		res_b.row  = sat_pos(row_post);
		res_b.col  = sat_pos(col_post);
		res_b.last = 1'b1;
		push_a     = a_v ? res_a : res_b;
		push_b     = res_b;
		push_n     = proc ? (2'(a_v) + 2'(b_v)) : 2'd0;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ctt_pkg::MODE_IDLE;
			quote_q <= '0;
			row_q   <= POS_BITS'(1);
			col_q   <= POS_BITS'(1);
			ended_q <= 1'b0;
		end else if (proc) begin
			mode_q  <= mode_nx;
			quote_q <= quote_nx;
			row_q   <= row_post;
			col_q   <= col_post;
			ended_q <= ended_nx;
		end
	end

	ctt_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_a     (push_a),
		.push_b     (push_b),
		.pop        (out_ch.ready),
		.head_valid (head_valid),
		.head       (head),
		.level      (level)
	);

	// result port
	assign out_ch.valid    = head_valid;
	assign out_ch.kind     = head.kind;
	assign out_ch.out_byte = head.data;
	assign out_ch.row      = head.row;
	assign out_ch.col      = head.col;
	assign out_ch.last     = head.last;

endmodule

>>> design/ctt_checker.sv
// ----------------------------------------------------------------------------
// ctt_checker: port-level checks of the config text tokenizer
// Watches the result channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module ctt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [ctt_pkg::KIND_W-1:0]     kind,
	input logic [ctt_pkg::BYTE_W-1:0]     out_byte,
	input logic [ctt_pkg::OUT_POS_W-1:0]  row,
	input logic [ctt_pkg::OUT_POS_W-1:0]  col,
	input logic                           last
);

	// a stalled result beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(out_byte) && $stable(row)
			&& $stable(col) && $stable(last))
		else $error("result payload changed while stalled");

	// only name characters carry a byte
	a_byte_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != ctt_pkg::KIND_NAME_CHAR) |-> out_byte == '0)
		else $error("byte on a result that is not a name character");

	// positions are one-based
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row != '0) && (col != '0))
		else $error("zero row or column");

	// end markers always close their byte's results
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == ctt_pkg::KIND_INPUT_END || kind == ctt_pkg::KIND_AFTER_END)
			|-> last)
		else $error("end marker not flagged as last");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.kind      (out_ch.kind),
	.out_byte  (out_ch.out_byte),
	.row       (out_ch.row),
	.col       (out_ch.col),
	.last      (out_ch.last)
);
